// ----- sv/rx_link_calibration_sequencer_core_macros.svh -----
// Assertion macros shared by the calibration sequencer RTL.
`ifndef RX_LINK_CALIBRATION_SEQUENCER_CORE_MACROS_SVH
`define RX_LINK_CALIBRATION_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RLCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RLCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/rlcs_pkg.sv -----
// Types, codes and helper functions of the receive calibration sequencer.
package rlcs_pkg;

   localparam int TIMER_BITS    = 16;
   localparam int ELAPSED_BITS  = 10;
   localparam int LIMIT_BITS    = 16;
   localparam int ATTEMPT_BITS  = 8;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int SUM_BITS =
      ((TIMER_BITS > ELAPSED_BITS) ? TIMER_BITS : ELAPSED_BITS) + 1;
   localparam int CMP_BITS =
      (TIMER_BITS > LIMIT_BITS) ? TIMER_BITS : LIMIT_BITS;

   typedef logic [TIMER_BITS-1:0]   timer_type;
   typedef logic [ELAPSED_BITS-1:0] elapsed_type;
   typedef logic [LIMIT_BITS-1:0]   limit_type;
   typedef logic [ATTEMPT_BITS-1:0] attempt_type;

   // Request opcodes
   localparam logic OP_STEP = 1'b0;
   localparam logic OP_INIT = 1'b1;

   // PCS control actions
   localparam logic [2:0] CTRL_NONE      = 3'd0;
   localparam logic [2:0] CTRL_TX_RXCLK  = 3'd1;
   localparam logic [2:0] CTRL_RX_RESET  = 3'd2;
   localparam logic [2:0] CTRL_RX_ENABLE = 3'd3;
   localparam logic [2:0] CTRL_TX_TXCLK  = 3'd4;

   // Phase tracker actions
   localparam logic [1:0] TRK_NONE    = 2'd0;
   localparam logic [1:0] TRK_DISABLE = 2'd1;
   localparam logic [1:0] TRK_RESTART = 2'd2;

   // Reported state codes
   localparam logic [2:0] CODE_INIT      = 3'd0;
   localparam logic [2:0] CODE_START     = 3'd1;
   localparam logic [2:0] CODE_RESET_PCS = 3'd2;
   localparam logic [2:0] CODE_WAIT_LOCK = 3'd3;
   localparam logic [2:0] CODE_VALIDATE  = 3'd4;
   localparam logic [2:0] CODE_RESTART   = 3'd5;
   localparam logic [2:0] CODE_DONE      = 3'd6;

   // Register indexes
   localparam logic [2:0] REG_LPDC_SUPPORTED   = 3'd0;
   localparam logic [2:0] REG_ANY_LPDC_PORTS   = 3'd1;
   localparam logic [2:0] REG_EARLYUP_WAIT_MS  = 3'd2;
   localparam logic [2:0] REG_LINK_WAIT_MS     = 3'd3;
   localparam logic [2:0] REG_ALIGN_WAIT_MS    = 3'd4;
   localparam logic [2:0] REG_ALIGN_TO_LINK_MS = 3'd5;
   localparam logic [2:0] REG_RESTART_WAIT_MS  = 3'd6;
   localparam logic [2:0] REG_MIN_CALIB_MS     = 3'd7;

   // Register reset values
   localparam limit_type RST_EARLYUP_WAIT_MS  = 16'd10;
   localparam limit_type RST_LINK_WAIT_MS     = 16'd100;
   localparam limit_type RST_ALIGN_WAIT_MS    = 16'd1;
   localparam limit_type RST_ALIGN_TO_LINK_MS = 16'd5000;
   localparam limit_type RST_RESTART_WAIT_MS  = 16'd100;
   localparam limit_type RST_MIN_CALIB_MS     = 16'd20000;

   localparam attempt_type ATTEMPT_MAX = '1;

   typedef enum logic [6:0] {
      ST_INIT      = 7'b0000001,
      ST_START     = 7'b0000010,
      ST_RESET_PCS = 7'b0000100,
      ST_WAIT_LOCK = 7'b0001000,
      ST_VALIDATE  = 7'b0010000,
      ST_RESTART   = 7'b0100000,
      ST_DONE      = 7'b1000000
   } seq_state_type;

   typedef struct packed {
      logic        opcode;
      logic        port_in_use;
      logic        link_up_event;
      logic        status_read_ok;
      logic        early_link;
      logic        rx_aligned;
      logic        tx_setup_done;
      logic        phase_ready;
      elapsed_type elapsed_ms;
   } req_type;

   typedef struct packed {
      logic        done_res;
      logic [2:0]  state_now;
      logic [2:0]  ctrl_action;
      logic [1:0]  tracker_action;
      attempt_type attempts;
   } rsp_type;

   typedef struct packed {
      logic      lpdc_supported;
      logic      any_lpdc_ports;
      limit_type earlyup_wait_ms;
      limit_type link_wait_ms;
      limit_type align_wait_ms;
      limit_type align_to_link_ms;
      limit_type restart_wait_ms;
      limit_type min_calib_ms;
   } cfg_type;

   typedef struct packed {
      timer_type earlyup;
      timer_type link;
      timer_type align;
      timer_type align_link;
      timer_type restart;
      timer_type min_calib;
   } timers_type;

   function automatic timer_type tick(timer_type t, elapsed_type el);
      logic [SUM_BITS-1:0] s;
      s = SUM_BITS'(t) + SUM_BITS'(el);
      if (s > SUM_BITS'({TIMER_BITS{1'b1}})) begin
         return '1;
      end
      return s[TIMER_BITS-1:0];
   endfunction

   function automatic logic expired(timer_type t, limit_type limit);
      return CMP_BITS'(t) >= CMP_BITS'(limit);
   endfunction

   function automatic logic [2:0] state_code(seq_state_type st);
      logic [2:0] code;
      case (st)
         ST_INIT:      code = CODE_INIT;
         ST_START:     code = CODE_START;
         ST_RESET_PCS: code = CODE_RESET_PCS;
         ST_WAIT_LOCK: code = CODE_WAIT_LOCK;
         ST_VALIDATE:  code = CODE_VALIDATE;
         ST_RESTART:   code = CODE_RESTART;
         ST_DONE:      code = CODE_DONE;
         default:      code = CODE_INIT;
      endcase
      return code;
   endfunction

endpackage

// ----- sv/rlcs_req_if.sv -----
// Request channel: valid, ready and one sequencer command.
interface rlcs_req_if;
   import rlcs_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- sv/rlcs_rsp_if.sv -----
// Response channel: valid, ready and one sequencer result.
interface rlcs_rsp_if;
   import rlcs_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- sv/rlcs_csr.sv -----
// APB register bank holding the sequencer limits and mode bits.
module rlcs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rlcs_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [rlcs_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [rlcs_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready,
   output rlcs_pkg::cfg_type                    cfg
);
   import rlcs_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_LPDC_SUPPORTED:   cfg_in.lpdc_supported   = csr_pwdata[0];
            REG_ANY_LPDC_PORTS:   cfg_in.any_lpdc_ports   = csr_pwdata[0];
            REG_EARLYUP_WAIT_MS:  cfg_in.earlyup_wait_ms  = csr_pwdata[LIMIT_BITS-1:0];
            REG_LINK_WAIT_MS:     cfg_in.link_wait_ms     = csr_pwdata[LIMIT_BITS-1:0];
            REG_ALIGN_WAIT_MS:    cfg_in.align_wait_ms    = csr_pwdata[LIMIT_BITS-1:0];
            REG_ALIGN_TO_LINK_MS: cfg_in.align_to_link_ms = csr_pwdata[LIMIT_BITS-1:0];
            REG_RESTART_WAIT_MS:  cfg_in.restart_wait_ms  = csr_pwdata[LIMIT_BITS-1:0];
            REG_MIN_CALIB_MS:     cfg_in.min_calib_ms     = csr_pwdata[LIMIT_BITS-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LPDC_SUPPORTED:   csr_prdata = CSR_DATA_BITS'(cfg_ff.lpdc_supported);
         REG_ANY_LPDC_PORTS:   csr_prdata = CSR_DATA_BITS'(cfg_ff.any_lpdc_ports);
         REG_EARLYUP_WAIT_MS:  csr_prdata = CSR_DATA_BITS'(cfg_ff.earlyup_wait_ms);
         REG_LINK_WAIT_MS:     csr_prdata = CSR_DATA_BITS'(cfg_ff.link_wait_ms);
         REG_ALIGN_WAIT_MS:    csr_prdata = CSR_DATA_BITS'(cfg_ff.align_wait_ms);
         REG_ALIGN_TO_LINK_MS: csr_prdata = CSR_DATA_BITS'(cfg_ff.align_to_link_ms);
         REG_RESTART_WAIT_MS:  csr_prdata = CSR_DATA_BITS'(cfg_ff.restart_wait_ms);
         REG_MIN_CALIB_MS:     csr_prdata = CSR_DATA_BITS'(cfg_ff.min_calib_ms);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lpdc_supported   <= 1'b0;
         cfg_ff.any_lpdc_ports   <= 1'b0;
         cfg_ff.earlyup_wait_ms  <= RST_EARLYUP_WAIT_MS;
         cfg_ff.link_wait_ms     <= RST_LINK_WAIT_MS;
         cfg_ff.align_wait_ms    <= RST_ALIGN_WAIT_MS;
         cfg_ff.align_to_link_ms <= RST_ALIGN_TO_LINK_MS;
         cfg_ff.restart_wait_ms  <= RST_RESTART_WAIT_MS;
         cfg_ff.min_calib_ms     <= RST_MIN_CALIB_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/rx_link_calibration_sequencer_core.sv -----
// Receive-path calibration sequencer: input register, state update, result register.
//
//   channel   direction  handshake            payload
//   req_ch    in         valid/ready          opcode, status flags, elapsed_ms
//   rsp_ch    out        valid/ready          done_res, state_now, actions, attempts
//   csr_*     in         APB, pready tied 1   eight limit and mode registers
//
// One request per cycle sustained while rsp_ch.ready is high; a response is valid once the accepted
// request has passed the input register and then the state update into the result register.
// The state machine, timers and attempt count update in the same cycle that loads
// the result, so consecutive requests see each other's effects with no bubble.
// Reset is synchronous and clears state, timers and both valid flags; no clearing pass.
// A stalled response holds the input stage; one request waits there before req_ch.ready drops.
`include "rx_link_calibration_sequencer_core_macros.svh"

module rx_link_calibration_sequencer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   rlcs_req_if.sink                             req_ch,
   rlcs_rsp_if.source                           rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [rlcs_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [rlcs_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [rlcs_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import rlcs_pkg::*;

   cfg_type       cfg;

   logic          s1_valid_ff;
   logic          s1_valid_in;
   req_type       s1_data_ff;
   logic          s1_adv;
   logic          req_take;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;

   seq_state_type state_ff;
   seq_state_type state_in;
   logic          entered_ff;
   logic          entered_in;
   timers_type    timers_ff;
   timers_type    timers_in;
   attempt_type   attempt_ff;
   attempt_type   attempt_in;

   logic          sup;
   logic          link;
   logic          rd_ok;
   logic          early;
   logic          aligned;
   logic          fired;
   seq_state_type step_next;

   rlcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake and pipeline flow
   assign s1_adv       = s1_valid_ff & (~rsp_valid_ff | rsp_ch.ready);
   assign req_ch.ready = ~s1_valid_ff | s1_adv;
   assign req_take     = req_ch.valid & req_ch.ready;
   assign s1_valid_in  = req_take | (s1_valid_ff & ~s1_adv);
   assign rsp_valid_in = s1_adv | (rsp_valid_ff & ~rsp_ch.ready);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   assign sup     = cfg.lpdc_supported;
   assign link    = s1_data_ff.link_up_event;
   assign rd_ok   = sup & s1_data_ff.status_read_ok;
   assign early   = rd_ok & s1_data_ff.early_link;
   assign aligned = rd_ok & s1_data_ff.rx_aligned;

   always_comb begin
      timers_in   = timers_ff;
      state_in    = state_ff;
      entered_in  = entered_ff;
      attempt_in  = attempt_ff;
      step_next   = state_ff;
      fired       = 1'b0;
      rsp_data_in.done_res       = 1'b0;
      rsp_data_in.ctrl_action    = CTRL_NONE;
      rsp_data_in.tracker_action = TRK_NONE;

      if (s1_data_ff.opcode == OP_INIT) begin
         timers_in  = '0;
         state_in   = ST_INIT;
         entered_in = 1'b1;
      end else if (!s1_data_ff.port_in_use) begin
         rsp_data_in.done_res = 1'b1;
      end else begin
         timers_in.earlyup    = tick(timers_ff.earlyup, s1_data_ff.elapsed_ms);
         timers_in.link       = tick(timers_ff.link, s1_data_ff.elapsed_ms);
         timers_in.align      = tick(timers_ff.align, s1_data_ff.elapsed_ms);
         timers_in.align_link = tick(timers_ff.align_link, s1_data_ff.elapsed_ms);
         timers_in.restart    = tick(timers_ff.restart, s1_data_ff.elapsed_ms);
         timers_in.min_calib  = tick(timers_ff.min_calib, s1_data_ff.elapsed_ms);

         case (state_ff)
            ST_INIT: begin
               if (cfg.any_lpdc_ports) begin
                  if (sup ? early : link) begin
                     timers_in.min_calib = '0;
                     step_next = ST_START;
                     fired     = 1'b1;
                  end
               end else begin
                  step_next = ST_START;
                  fired     = 1'b1;
               end
            end
            ST_START: begin
               if (s1_data_ff.tx_setup_done) begin
                  if (sup) begin
                     if (entered_ff) begin
                        timers_in.earlyup = '0;
                     end
                     if (expired(timers_in.earlyup, cfg.earlyup_wait_ms)) begin
                        rsp_data_in.ctrl_action = CTRL_TX_RXCLK;
                        if (early) begin
                           attempt_in = '0;
                           rsp_data_in.tracker_action = TRK_DISABLE;
                           step_next = ST_RESET_PCS;
                           fired     = 1'b1;
                        end else begin
                           timers_in.earlyup = '0;
                        end
                     end
                  end else begin
                     step_next = ST_DONE;
                     fired     = 1'b1;
                  end
               end
            end
            ST_RESET_PCS: begin
               if (entered_ff) begin
                  timers_in.link = '0;
               end
               if (early) begin
                  rsp_data_in.ctrl_action = CTRL_RX_RESET;
                  if (attempt_ff != ATTEMPT_MAX) begin
                     attempt_in = attempt_ff + 1'b1;
                  end
                  step_next = ST_WAIT_LOCK;
                  fired     = 1'b1;
               end else if (expired(timers_in.link, cfg.link_wait_ms)) begin
                  step_next = ST_INIT;
                  fired     = 1'b1;
               end
            end
            ST_WAIT_LOCK: begin
               if (entered_ff) begin
                  timers_in.link  = '0;
                  timers_in.align = '0;
               end
               if (early) begin
                  if (expired(timers_in.align, cfg.align_wait_ms)) begin
                     fired = 1'b1;
                     if (aligned) begin
                        rsp_data_in.tracker_action = TRK_RESTART;
                        step_next = ST_VALIDATE;
                     end else if (expired(timers_in.min_calib, cfg.min_calib_ms)) begin
                        step_next = ST_INIT;
                     end else begin
                        step_next = ST_RESET_PCS;
                     end
                  end
               end else if (expired(timers_in.link, cfg.link_wait_ms)) begin
                  step_next = ST_INIT;
                  fired     = 1'b1;
               end
            end
            ST_VALIDATE: begin
               if (s1_data_ff.phase_ready) begin
                  rsp_data_in.ctrl_action    = CTRL_RX_ENABLE;
                  rsp_data_in.tracker_action = TRK_DISABLE;
                  step_next = ST_DONE;
                  fired     = 1'b1;
               end else if (!early || expired(timers_in.min_calib, cfg.min_calib_ms)) begin
                  step_next = ST_INIT;
                  fired     = 1'b1;
               end
            end
            ST_RESTART: begin
               if (entered_ff) begin
                  timers_in.restart = '0;
                  rsp_data_in.ctrl_action = CTRL_TX_TXCLK;
               end else if (expired(timers_in.restart, cfg.restart_wait_ms)) begin
                  step_next = ST_INIT;
                  fired     = 1'b1;
               end
            end
            ST_DONE: begin
               if (sup && entered_ff) begin
                  timers_in.align_link = '0;
               end
               if (sup && !early) begin
                  step_next = ST_INIT;
                  fired     = 1'b1;
               end else if (sup && !link &&
                            expired(timers_in.align_link, cfg.align_to_link_ms)) begin
                  step_next = ST_RESTART;
                  fired     = 1'b1;
               end else if (cfg.any_lpdc_ports) begin
                  rsp_data_in.done_res =
                     link & expired(timers_in.min_calib, cfg.min_calib_ms);
               end else begin
                  rsp_data_in.done_res = link;
               end
            end
            default: begin
               step_next = ST_INIT;
               fired     = 1'b1;
            end
         endcase

         state_in   = step_next;
         entered_in = fired;
      end

      rsp_data_in.state_now = state_code(state_in);
      rsp_data_in.attempts  = attempt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_INIT;
         entered_ff   <= 1'b1;
         timers_ff    <= '0;
         attempt_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            state_ff   <= state_in;
            entered_ff <= entered_in;
            timers_ff  <= timers_in;
            attempt_ff <= attempt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_ch.data;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `RLCS_ASSERT_NEXT(a_init_clears, clock, reset,
      s1_adv && s1_data_ff.opcode == OP_INIT,
      state_ff == ST_INIT && entered_ff && timers_ff == '0,
      "init request did not return the sequencer to INIT with cleared timers")
   `RLCS_ASSERT_NEXT(a_state_holds, clock, reset,
      !s1_adv,
      $stable(state_ff) && $stable(attempt_ff) && $stable(timers_ff),
      "sequencer state moved without a request advancing")
   `RLCS_ASSERT_NEXT(a_result_loaded, clock, reset,
      s1_adv,
      rsp_valid_ff,
      "advanced request produced no response")
   `RLCS_ASSERT_NOW(a_stall_cause, clock, reset,
      !req_ch.ready,
      s1_valid_ff && rsp_valid_ff && !rsp_ch.ready,
      "request side stalled while the pipeline could move")

endmodule
